FILE: rtl/salsa_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salsa_pkg
// Shared types, constants and functions of the Salsa20 stream cipher engine.
// ----------------------------------------------------------------------------
package salsa_pkg;

   localparam int DOUBLE_ROUNDS_DEFAULT = 10;

   localparam logic [31:0] SIGMA_0 = 32'h61707865;
   localparam logic [31:0] SIGMA_1 = 32'h3320646e;
   localparam logic [31:0] SIGMA_2 = 32'h79622d32;
   localparam logic [31:0] SIGMA_3 = 32'h6b206574;

   localparam int WORDS = 16;
   localparam int WORD_W = 32;
   localparam int WORD_AW = 4;

   localparam logic [2:0] CSR_KEY_01 = 3'd0;
   localparam logic [2:0] CSR_KEY_23 = 3'd1;
   localparam logic [2:0] CSR_KEY_45 = 3'd2;
   localparam logic [2:0] CSR_KEY_67 = 3'd3;
   localparam logic [2:0] CSR_NONCE  = 3'd4;

   typedef struct packed {
      logic [63:0] key01;
      logic [63:0] key23;
      logic [63:0] key45;
      logic [63:0] key67;
      logic [63:0] nonce;
   } salsa_cfg_type;

   typedef struct packed {
      logic                wr_en;
      logic [WORD_AW-1:0]  addr;
      logic [WORD_W-1:0]   data;
   } ks_wr_type;

   // Initial block word at a given index (standard Salsa20 layout)
   function automatic logic [31:0] init_word(logic [3:0] idx, salsa_cfg_type cfg,
                                             logic [63:0] ctr);
      logic [31:0] w;
      unique case (idx)
         4'd0:  w = SIGMA_0;
         4'd1:  w = cfg.key01[31:0];
         4'd2:  w = cfg.key01[63:32];
         4'd3:  w = cfg.key23[31:0];
         4'd4:  w = cfg.key23[63:32];
         4'd5:  w = SIGMA_1;
         4'd6:  w = cfg.nonce[31:0];
         4'd7:  w = cfg.nonce[63:32];
         4'd8:  w = ctr[31:0];
         4'd9:  w = ctr[63:32];
         4'd10: w = SIGMA_2;
         4'd11: w = cfg.key45[31:0];
         4'd12: w = cfg.key45[63:32];
         4'd13: w = cfg.key67[31:0];
         4'd14: w = cfg.key67[63:32];
         4'd15: w = SIGMA_3;
         default: w = SIGMA_0;
      endcase
      return w;
   endfunction

   // State word index for quarter q (column round 0..3, row round 4..7), lane j
   function automatic logic [3:0] qr_index(logic [2:0] q, logic [1:0] j);
      logic [15:0] row;
      unique case (q)
         3'd0: row = {4'd12, 4'd8,  4'd4,  4'd0};
         3'd1: row = {4'd1,  4'd13, 4'd9,  4'd5};
         3'd2: row = {4'd6,  4'd2,  4'd14, 4'd10};
         3'd3: row = {4'd11, 4'd7,  4'd3,  4'd15};
         3'd4: row = {4'd3,  4'd2,  4'd1,  4'd0};
         3'd5: row = {4'd4,  4'd7,  4'd6,  4'd5};
         3'd6: row = {4'd9,  4'd8,  4'd11, 4'd10};
         3'd7: row = {4'd14, 4'd13, 4'd12, 4'd15};
         default: row = 16'd0;
      endcase
      return row[j*4 +: 4];
   endfunction

endpackage
`default_nettype wire

FILE: rtl/salsa20_stream_cipher.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salsa20_stream_cipher
// Salsa20 encrypt/decrypt engine, one message byte per transfer.
//
// req_ carries one message byte (tdata) and a first-of-message flag (tuser);
// rsp_ returns the byte XORed with the matching keystream byte. The csr_
// port writes the four 64-bit key registers (index 0..3) and the nonce
// (index 4); other indexes are dropped. The user must write them only
// while the engine is idle; the block itself does not enforce this.
// A byte inside a block is XORed with its keystream byte in state S_OUT
// and the result goes to the output register; no new byte is taken until
// the engine is back in idle. The first byte of each 64-byte block, and
// every byte flagged first-of-message, first builds a new block: the state
// is loaded, then each double round runs 8 quarter rounds (each reads four
// words from the working RAM, makes 4 uses of the shared add-rotate-xor
// unit and does 4 write-backs), then the final add and a handoff through
// S_READ and S_OUT. req_tready stays low while a byte is in work.
// Reset clears the keys, nonce, block counter and byte position. A stalled
// result holds in the output register; the next byte is taken once it
// leaves.
// ----------------------------------------------------------------------------
module salsa20_stream_cipher #(
   parameter int DOUBLE_ROUNDS = salsa_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output logic             req_tready,
   input  wire logic [7:0]  req_tdata,   // [7:0] message_byte
   input  wire logic        req_tuser,   // [0] first_of_message
   output logic             rsp_tvalid,
   input  wire logic        rsp_tready,
   output logic      [7:0]  rsp_tdata,   // [7:0] result_byte
   input  wire logic        csr_wr_en,
   input  wire logic [2:0]  csr_index,
   input  wire logic [63:0] csr_wdata
);

   localparam logic [1:0] S_IDLE = 2'd0;
   localparam logic [1:0] S_GEN  = 2'd1;
   localparam logic [1:0] S_READ = 2'd2;
   localparam logic [1:0] S_OUT  = 2'd3;

   logic [1:0]               state_ff, state_in;
   salsa_pkg::salsa_cfg_type cfg_ff;
   logic [63:0]              counter_ff, counter_in;
   logic [5:0]               pos_ff, pos_in;
   logic [7:0]               msg_ff;
   logic                     rsp_valid_ff, rsp_valid_in;
   logic [7:0]               rsp_data_ff, rsp_data_in;

   logic                     accept;
   logic [5:0]               pos_eff;
   logic [63:0]              counter_eff;
   logic                     gen_start;
   logic                     gen_done;
   salsa_pkg::ks_wr_type     ks_wr;
   logic [3:0]               ks_rd_addr;
   logic [31:0]              ks_rd_data;
   logic [7:0]               ks_byte;

   assign req_tready  = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_tready);
   assign accept      = req_tvalid && req_tready;
   assign pos_eff     = req_tuser ? 6'd0 : pos_ff;
   assign counter_eff = req_tuser ? 64'd0 : counter_ff;
   assign gen_start   = accept && (pos_eff == 6'd0);
   assign ks_rd_addr  = (state_ff == S_IDLE) ? pos_eff[5:2] : pos_ff[5:2];
   assign ks_byte     = 8'(ks_rd_data >> {pos_ff[1:0], 3'b000});

   salsa_core #(
      .DOUBLE_ROUNDS (DOUBLE_ROUNDS)
   ) u_core (
      .clock   (clock),
      .reset   (reset),
      .start   (gen_start),
      .cfg     (cfg_ff),
      .counter (counter_ff),
      .ks_wr   (ks_wr),
      .done    (gen_done)
   );

   salsa_ram #(
      .WIDTH (salsa_pkg::WORD_W),
      .DEPTH (salsa_pkg::WORDS)
   ) u_ks_ram (
      .clock   (clock),
      .wr_en   (ks_wr.wr_en),
      .wr_addr (ks_wr.addr),
      .wr_data (ks_wr.data),
      .rd_addr (ks_rd_addr),
      .rd_data (ks_rd_data)
   );

   always_comb begin
      state_in     = state_ff;
      counter_in   = counter_ff;
      pos_in       = pos_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               counter_in = counter_eff;
               pos_in     = pos_eff;
               state_in   = gen_start ? S_GEN : S_OUT;
            end
         end
         S_GEN: begin
            if (gen_done) begin
               counter_in = counter_ff + 64'd1;
               state_in   = S_READ;
            end
         end
         S_READ: begin
            state_in = S_OUT;
         end
         S_OUT: begin
            rsp_valid_in = 1'b1;
            rsp_data_in  = msg_ff ^ ks_byte;
            pos_in       = pos_ff + 6'd1;
            state_in     = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         counter_ff   <= 64'd0;
         pos_ff       <= 6'd0;
         rsp_valid_ff <= 1'b0;
         cfg_ff       <= '0;
      end else begin
         state_ff     <= state_in;
         counter_ff   <= counter_in;
         pos_ff       <= pos_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            unique case (csr_index)
               salsa_pkg::CSR_KEY_01: cfg_ff.key01 <= csr_wdata;
               salsa_pkg::CSR_KEY_23: cfg_ff.key23 <= csr_wdata;
               salsa_pkg::CSR_KEY_45: cfg_ff.key45 <= csr_wdata;
               salsa_pkg::CSR_KEY_67: cfg_ff.key67 <= csr_wdata;
               salsa_pkg::CSR_NONCE:  cfg_ff.nonce <= csr_wdata;
               default: cfg_ff <= cfg_ff;
            endcase
         end
      end
      rsp_data_ff <= rsp_data_in;
      if (accept) begin
         msg_ff <= req_tdata;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

endmodule
`default_nettype wire

FILE: rtl/salsa_ram.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salsa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module salsa_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16
) (
   input  wire logic                     clock,
   input  wire logic                     wr_en,
   input  wire logic [$clog2(DEPTH)-1:0] wr_addr,
   input  wire logic [WIDTH-1:0]         wr_data,
   input  wire logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic      [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end

endmodule
`default_nettype wire

FILE: rtl/salsa_arx.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salsa_arx
// Shared add-rotate-xor unit: one quarter-round step per use.
// ----------------------------------------------------------------------------
module salsa_arx (
   input  wire logic [1:0]  step,
   input  wire logic [31:0] opnd_x,
   input  wire logic [31:0] opnd_y,
   input  wire logic [31:0] target,
   output logic      [31:0] result
);

   logic [31:0] sum;
   logic [31:0] rot;

   always_comb begin
      sum = opnd_x + opnd_y;
      unique case (step)
         2'd0: rot = {sum[24:0], sum[31:25]};
         2'd1: rot = {sum[22:0], sum[31:23]};
         2'd2: rot = {sum[18:0], sum[31:19]};
         2'd3: rot = {sum[13:0], sum[31:14]};
         default: rot = sum;
      endcase
      result = target ^ rot;
   end

endmodule
`default_nettype wire

FILE: rtl/salsa_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// salsa_core
// Block generator: sequences one ARX unit over a working-state RAM and writes
// the finished keystream block (state plus input words) word by word.
// ----------------------------------------------------------------------------
module salsa_core #(
   parameter int DOUBLE_ROUNDS = salsa_pkg::DOUBLE_ROUNDS_DEFAULT
) (
   input  wire logic                      clock,
   input  wire logic                      reset,
   input  wire logic                      start,
   input  wire salsa_pkg::salsa_cfg_type  cfg,
   input  wire logic [63:0]               counter,
   output salsa_pkg::ks_wr_type           ks_wr,
   output logic                           done
);

   localparam int RND_W = $clog2(DOUBLE_ROUNDS);
   localparam logic [RND_W-1:0] RND_LAST = RND_W'(DOUBLE_ROUNDS - 1);

   localparam logic [2:0] C_IDLE  = 3'd0;
   localparam logic [2:0] C_INIT  = 3'd1;
   localparam logic [2:0] C_LOAD  = 3'd2;
   localparam logic [2:0] C_ARX   = 3'd3;
   localparam logic [2:0] C_STORE = 3'd4;
   localparam logic [2:0] C_FINAL = 3'd5;

   logic [2:0]       state_ff, state_in;
   logic [4:0]       cnt_ff, cnt_in;
   logic [2:0]       quarter_ff, quarter_in;
   logic [RND_W-1:0] round_ff, round_in;
   logic             done_ff, done_in;
   logic [31:0]      lane_ff [4];
   logic [31:0]      lane_in [4];

   logic             wr_en;
   logic [3:0]       wr_addr;
   logic [31:0]      wr_data;
   logic [3:0]       rd_addr;
   logic [31:0]      rd_data;

   logic [1:0]       prev_lane;
   logic [3:0]       prev_word;
   logic [1:0]       step;
   logic [31:0]      opnd_x, opnd_y, target, arx_out;

   assign prev_lane = 2'(cnt_ff - 5'd1);
   assign prev_word = 4'(cnt_ff - 5'd1);
   assign step      = cnt_ff[1:0];

   salsa_ram #(
      .WIDTH (salsa_pkg::WORD_W),
      .DEPTH (salsa_pkg::WORDS)
   ) u_work_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   always_comb begin
      unique case (step)
         2'd0: begin
            opnd_x = lane_ff[0]; opnd_y = lane_ff[3]; target = lane_ff[1];
         end
         2'd1: begin
            opnd_x = lane_ff[1]; opnd_y = lane_ff[0]; target = lane_ff[2];
         end
         2'd2: begin
            opnd_x = lane_ff[2]; opnd_y = lane_ff[1]; target = lane_ff[3];
         end
         2'd3: begin
            opnd_x = lane_ff[3]; opnd_y = lane_ff[2]; target = lane_ff[0];
         end
         default: begin
            opnd_x = lane_ff[0]; opnd_y = lane_ff[3]; target = lane_ff[1];
         end
      endcase
   end

   salsa_arx u_arx (
      .step   (step),
      .opnd_x (opnd_x),
      .opnd_y (opnd_y),
      .target (target),
      .result (arx_out)
   );

   always_comb begin
      state_in   = state_ff;
      cnt_in     = cnt_ff;
      quarter_in = quarter_ff;
      round_in   = round_ff;
      done_in    = 1'b0;
      lane_in    = lane_ff;
      wr_en      = 1'b0;
      wr_addr    = cnt_ff[3:0];
      wr_data    = salsa_pkg::init_word(cnt_ff[3:0], cfg, counter);
      rd_addr    = salsa_pkg::qr_index(quarter_ff, cnt_ff[1:0]);
      ks_wr.wr_en = 1'b0;
      ks_wr.addr  = prev_word;
      ks_wr.data  = rd_data + salsa_pkg::init_word(prev_word, cfg, counter);

      unique case (state_ff)
         C_IDLE: begin
            if (start) begin
               state_in = C_INIT;
               cnt_in   = 5'd0;
            end
         end
         C_INIT: begin
            wr_en  = 1'b1;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd15) begin
               state_in   = C_LOAD;
               cnt_in     = 5'd0;
               quarter_in = 3'd0;
               round_in   = '0;
            end
         end
         C_LOAD: begin
            if (cnt_ff != 5'd0) begin
               lane_in[prev_lane] = rd_data;
            end
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd4) begin
               state_in = C_ARX;
               cnt_in   = 5'd0;
            end
         end
         C_ARX: begin
            lane_in[2'(step + 2'd1)] = arx_out;
            cnt_in = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               state_in = C_STORE;
               cnt_in   = 5'd0;
            end
         end
         C_STORE: begin
            wr_en   = 1'b1;
            wr_addr = salsa_pkg::qr_index(quarter_ff, cnt_ff[1:0]);
            wr_data = lane_ff[cnt_ff[1:0]];
            cnt_in  = cnt_ff + 5'd1;
            if (cnt_ff == 5'd3) begin
               cnt_in     = 5'd0;
               quarter_in = quarter_ff + 3'd1;
               state_in   = C_LOAD;
               if (quarter_ff == 3'd7) begin
                  round_in = round_ff + RND_W'(1);
                  if (round_ff == RND_LAST) begin
                     state_in = C_FINAL;
                  end
               end
            end
         end
         C_FINAL: begin
            rd_addr     = cnt_ff[3:0];
            ks_wr.wr_en = (cnt_ff != 5'd0);
            cnt_in      = cnt_ff + 5'd1;
            if (cnt_ff == 5'd16) begin
               state_in = C_IDLE;
               done_in  = 1'b1;
            end
         end
         default: begin
            state_in = C_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= C_IDLE;
         cnt_ff     <= 5'd0;
         quarter_ff <= 3'd0;
         round_ff   <= '0;
         done_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         cnt_ff     <= cnt_in;
         quarter_ff <= quarter_in;
         round_ff   <= round_in;
         done_ff    <= done_in;
      end
      lane_ff <= lane_in;
   end

   assign done = done_ff;

endmodule
`default_nettype wire
